### hw/rtl/fbc_pkg.sv
package fbc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned SUM_W  = 64;

    // fletcher modulus, one less than two to the word width
    localparam logic [WORD_W-1:0] FL_MOD = {WORD_W{1'b1}};

    // register reset value for the mode bit
    localparam logic VERIFY_MODE_RESET = 1'b1;

    // word position codes within a block
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_DATA   = 2'd2;

    // finished block handed from the accumulator to the finishing stages
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] sum_one;
        logic [WORD_W-1:0] sum_two;
        logic [SUM_W-1:0]  stored;
        logic              is_short;
        logic              vmode;
    } t_blk_sums;

    // (a + b) mod FL_MOD for a, b not above FL_MOD; one conditional subtract
    function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FL_MOD}) begin
            s = s - {1'b0, FL_MOD};
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

### hw/rtl/fbc_ifs.sv
interface fbc_in_if;
    logic                      valid;
    logic                      ready;
    logic [fbc_pkg::WORD_W-1:0] data_word;
    logic                      last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface fbc_out_if;
    logic                      valid;
    logic                      ready;
    logic [fbc_pkg::SUM_W-1:0] checksum;
    logic                      matches_res;
    logic                      short_block;

    modport source (output valid, output checksum, output matches_res,
                    output short_block, input ready);
    modport sink   (input valid, input checksum, input matches_res,
                    input short_block, output ready);
endinterface

### hw/rtl/fbc_accum.sv
module fbc_accum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_valid,
    input  logic [fbc_pkg::WORD_W-1:0] i_data_word,
    input  logic                       i_last_word,
    output fbc_pkg::t_blk_sums         o_blk
);

    logic                       r_mode;
    logic                       r_in_valid;
    logic [fbc_pkg::WORD_W-1:0] r_word;
    logic                       r_last;
    logic [fbc_pkg::WORD_W-1:0] r_sum_one;
    logic [fbc_pkg::WORD_W-1:0] r_sum_two;
    logic [1:0]                 r_pos;
    logic [fbc_pkg::SUM_W-1:0]  r_stored;
    fbc_pkg::t_blk_sums         r_blk;

    logic [fbc_pkg::WORD_W-1:0] n_sum_one;
    logic [fbc_pkg::WORD_W-1:0] n_sum_two;
    logic [1:0]                 n_pos;
    logic [fbc_pkg::SUM_W-1:0]  n_stored;
    logic                       step;

    assign step = r_in_valid && i_adv;

    // capture stored checksum words or fold the word into both sums
    always_comb begin
        n_sum_one = r_sum_one;
        n_sum_two = r_sum_two;
        n_stored  = r_stored;
        if (r_mode && (r_pos == fbc_pkg::POS_FIRST)) begin
            n_stored[fbc_pkg::WORD_W-1:0] = r_word;
        end else if (r_mode && (r_pos == fbc_pkg::POS_SECOND)) begin
            n_stored[fbc_pkg::SUM_W-1:fbc_pkg::WORD_W] = r_word;
        end else begin
            n_sum_one = fbc_pkg::mod_add(r_sum_one, r_word);
            n_sum_two = fbc_pkg::mod_add(r_sum_two, n_sum_one);
        end
        n_pos = (r_pos == fbc_pkg::POS_DATA) ? r_pos : r_pos + 2'd1;
    end

    // mode register, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fbc_pkg::VERIFY_MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_valid;
        end
        if (i_adv) begin
            r_word <= i_data_word;
            r_last <= i_last_word;
        end
    end

    // running block state, cleared after every last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_one <= '0;
            r_sum_two <= '0;
            r_pos     <= fbc_pkg::POS_FIRST;
            r_stored  <= '0;
        end else if (step) begin
            if (r_last) begin
                r_sum_one <= '0;
                r_sum_two <= '0;
                r_pos     <= fbc_pkg::POS_FIRST;
                r_stored  <= '0;
            end else begin
                r_sum_one <= n_sum_one;
                r_sum_two <= n_sum_two;
                r_pos     <= n_pos;
                r_stored  <= n_stored;
            end
        end
    end

    // finished block register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk.valid <= 1'b0;
        end else if (i_adv) begin
            r_blk.valid <= r_in_valid && r_last;
        end
        if (i_adv) begin
            r_blk.sum_one  <= n_sum_one;
            r_blk.sum_two  <= n_sum_two;
            r_blk.stored   <= n_stored;
            r_blk.is_short <= r_mode && (r_pos == fbc_pkg::POS_FIRST);
            r_blk.vmode    <= r_mode;
        end
    end

    assign o_blk = r_blk;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= fbc_pkg::POS_DATA)
        else $error("word position out of range");

    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_one != fbc_pkg::FL_MOD) && (r_sum_two != fbc_pkg::FL_MOD))
        else $error("running sum not reduced");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_last) |=> (r_pos == fbc_pkg::POS_FIRST) && (r_sum_one == '0)
            && (r_sum_two == '0) && (r_stored == '0))
        else $error("block state not cleared after last word");

endmodule

### hw/rtl/fbc_finish.sv
module fbc_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fbc_pkg::t_blk_sums  i_blk,
    output logic                o_adv,
    fbc_out_if.source           o_ch
);

    fbc_pkg::t_blk_sums         r_c;
    logic [fbc_pkg::WORD_W-1:0] r_check1;
    logic                       r_out_valid;
    logic [fbc_pkg::SUM_W-1:0]  r_checksum;
    logic                       r_match;
    logic                       r_short;
    logic                       r_out_vmode;

    logic [fbc_pkg::WORD_W-1:0] n_check1;
    logic [fbc_pkg::WORD_W-1:0] n_check2;
    logic [fbc_pkg::SUM_W-1:0]  n_checksum;

    // whole pipeline moves unless a result waits on a stalled receiver
    assign o_adv = !r_out_valid || o_ch.ready;

    // first check word
    assign n_check1 = fbc_pkg::FL_MOD - fbc_pkg::mod_add(i_blk.sum_one, i_blk.sum_two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else if (o_adv) begin
            r_c.valid <= i_blk.valid;
        end
        if (o_adv) begin
            r_c.sum_one  <= i_blk.sum_one;
            r_c.sum_two  <= i_blk.sum_two;
            r_c.stored   <= i_blk.stored;
            r_c.is_short <= i_blk.is_short;
            r_c.vmode    <= i_blk.vmode;
            r_check1     <= n_check1;
        end
    end

    // second check word and the compare with the stored checksum
    assign n_check2   = fbc_pkg::FL_MOD - fbc_pkg::mod_add(r_c.sum_one, r_check1);
    assign n_checksum = {n_check2, r_check1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_c.valid;
        end
        if (o_adv) begin
            r_checksum  <= n_checksum;
            r_match     <= r_c.vmode && !r_c.is_short && (n_checksum == r_c.stored);
            r_short     <= r_c.is_short;
            r_out_vmode <= r_c.vmode;
        end
    end

    assign o_ch.valid       = r_out_valid;
    assign o_ch.checksum    = r_checksum;
    assign o_ch.matches_res = r_match;
    assign o_ch.short_block = r_short;

    a_short_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_match && r_short))
        else $error("short block reported as matching");

    a_flags_need_verify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_vmode) |-> (!r_match && !r_short))
        else $error("verify flag raised outside verify mode");

    a_stall_freezes_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_adv |=> $stable(r_c.valid) && $stable(r_check1))
        else $error("inner stage moved during stall");

endmodule

### hw/rtl/fletcher64_block_checksum_top.sv
// fletcher-64 block checksum over a stream of 32-bit words
//
// i_word_ch carries one data word per transaction, with last_word on the
// final word of a block. o_sum_ch carries one result per block: the 64-bit
// checksum (check2 high, check1 low), a match flag and a short-block flag.
// i_cfg_we / i_cfg_wdata write the verify-mode bit; write it only while idle.
// In verify mode the first two words of each block are the stored checksum,
// low word first, and are kept out of the sums.
// Throughput: one word per cycle while no result waits on a stalled receiver,
// set by the add-and-reduce loop on the running sums. The result of a block
// passes through the input register, accumulator, check1 stage and output
// register after the transaction of its last word.
// Reset clears all pipeline valids and the block state, and sets verify
// mode. When the receiver holds ready low with a result waiting, the whole
// pipeline holds and i_word_ch.ready drops until the result is taken.
module fletcher64_block_checksum_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    fbc_in_if.sink     i_word_ch,
    fbc_out_if.source  o_sum_ch
);

    logic               adv;
    fbc_pkg::t_blk_sums blk;

    assign i_word_ch.ready = adv;

    // running sums and stored checksum capture
    fbc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_word_ch.valid),
        .i_data_word (i_word_ch.data_word),
        .i_last_word (i_word_ch.last_word),
        .o_blk       (blk)
    );

    // check words, compare and result register
    fbc_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk),
        .o_adv   (adv),
        .o_ch    (o_sum_ch)
    );

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // one checksum transaction as seen on the result channel
    typedef struct packed {
        logic [fbc_pkg::SUM_W-1:0] sum64;
        logic                      match_flag;
        logic                      short_flag;
    } t_sum_res;

    // directed stimulus row: a mode write or one data word
    typedef struct packed {
        logic                       is_cfg;
        logic                       cfg_val;
        logic [fbc_pkg::WORD_W-1:0] word;
        logic                       last;
        logic                       has_exp;
        logic [fbc_pkg::SUM_W-1:0]  exp_sum;
        logic                       exp_match;
        logic                       exp_short;
    } t_dir_row;

    localparam int N_DIR = 25;
    localparam logic [fbc_pkg::SUM_W-1:0] ALL_ONES = {fbc_pkg::SUM_W{1'b1}};
    localparam int TARGET_WORDS = 1650;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    fbc_in_if  word_ch ();
    fbc_out_if sum_ch ();

    fletcher64_block_checksum_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word_ch   (word_ch),
        .o_sum_ch    (sum_ch)
    );

    // short verify block, two-word verify blocks, sums at the modulus edges,
    // and mode changes part way through a block
    t_dir_row dir_tab [0:N_DIR-1] = '{
        '{1'b0, 1'b0, 32'h1234_5678, 1'b1, 1'b1, ALL_ONES, 1'b0, 1'b1},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, ALL_ONES, 1'b1, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, ALL_ONES, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0001, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, ALL_ONES, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, ALL_ONES, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFE, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h5555_5555, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h1111_1111, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h2222_2222, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h3333_3333, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hDEAD_BEEF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0BAD_F00D, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0}
    };

    // predictor state
    logic                       mode_q;
    logic [fbc_pkg::WORD_W-1:0] run_one;
    logic [fbc_pkg::WORD_W-1:0] run_two;
    logic [1:0]                 pos_q;
    logic [fbc_pkg::SUM_W-1:0]  stored_q;

    t_sum_res                   pending_sums [$];
    logic [fbc_pkg::WORD_W-1:0] blk_q [$];
    t_sum_res                   head_res;
    int                         err_cnt;
    int                         words_sent;
    int                         burst_left;
    int                         stall_left;
    int                         stall_style;
    logic [3:0]                 stall_pat;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

    // (a + b) mod the fletcher modulus, operands not above the modulus
    function automatic logic [fbc_pkg::WORD_W-1:0] add_mod_m(
        input logic [fbc_pkg::WORD_W-1:0] a,
        input logic [fbc_pkg::WORD_W-1:0] b);
        logic [fbc_pkg::WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, fbc_pkg::FL_MOD}) begin
            s = s - {1'b0, fbc_pkg::FL_MOD};
        end
        return s[fbc_pkg::WORD_W-1:0];
    endfunction

    // check words from the two running sums, check2 high
    function automatic logic [fbc_pkg::SUM_W-1:0] check_words(
        input logic [fbc_pkg::WORD_W-1:0] s1,
        input logic [fbc_pkg::WORD_W-1:0] s2);
        logic [fbc_pkg::WORD_W-1:0] c1;
        logic [fbc_pkg::WORD_W-1:0] c2;
        c1 = fbc_pkg::FL_MOD - add_mod_m(s1, s2);
        c2 = fbc_pkg::FL_MOD - add_mod_m(s1, c1);
        return {c2, c1};
    endfunction

    // checksum of a whole data block, used to build matching stored words
    function automatic logic [fbc_pkg::SUM_W-1:0] block_checksum(
        input logic [fbc_pkg::WORD_W-1:0] ws [$]);
        logic [fbc_pkg::WORD_W-1:0] s1;
        logic [fbc_pkg::WORD_W-1:0] s2;
        s1 = '0;
        s2 = '0;
        foreach (ws[k]) begin
            s1 = add_mod_m(s1, ws[k]);
            s2 = add_mod_m(s2, s1);
        end
        return check_words(s1, s2);
    endfunction

    // data words biased towards the modulus edges
    function automatic logic [fbc_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return fbc_pkg::FL_MOD;
            2:       return fbc_pkg::FL_MOD - 1;
            3:       return fbc_pkg::WORD_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic void clear_block();
        run_one  = '0;
        run_two  = '0;
        pos_q    = fbc_pkg::POS_FIRST;
        stored_q = '0;
    endfunction

    // one word through the checksum: capture or sum, then finish on last
    task automatic fletcher_step(input logic [fbc_pkg::WORD_W-1:0] w, input logic l,
                                 output bit done, output t_sum_res r);
        bit first;
        first = (pos_q == fbc_pkg::POS_FIRST);
        if (mode_q && pos_q == fbc_pkg::POS_FIRST) begin
            stored_q[fbc_pkg::WORD_W-1:0] = w;
        end else if (mode_q && pos_q == fbc_pkg::POS_SECOND) begin
            stored_q[fbc_pkg::SUM_W-1:fbc_pkg::WORD_W] = w;
        end else begin
            run_one = add_mod_m(run_one, w);
            run_two = add_mod_m(run_two, run_one);
        end
        if (pos_q != fbc_pkg::POS_DATA) begin
            pos_q = pos_q + 2'd1;
        end
        done = l;
        r    = '0;
        if (l) begin
            r.sum64      = check_words(run_one, run_two);
            r.short_flag = mode_q && first;
            r.match_flag = mode_q && !first && (r.sum64 == stored_q);
            clear_block();
        end
    endtask

    // drive one word, in bursts with random gaps, and log its expectation
    task automatic send_word(input logic [fbc_pkg::WORD_W-1:0] w, input logic l,
                             input bit typed, input t_sum_res typed_res);
        bit       done;
        t_sum_res r;
        if (burst_left == 0) begin
            @(negedge i_clk);
            word_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        @(negedge i_clk);
        word_ch.valid     <= 1'b1;
        word_ch.data_word <= w;
        word_ch.last_word <= l;
        @(posedge i_clk);
        while (!word_ch.ready) @(posedge i_clk);
        burst_left--;
        words_sent++;
        fletcher_step(w, l, done, r);
        if (done) begin
            pending_sums.push_back(typed ? typed_res : r);
        end
    endtask

    // stop sending and wait for every outstanding result, then some margin
    task automatic drain();
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_q = v;
    endtask

    // one random block; in verify mode mostly well-formed with a stored checksum
    task automatic run_block();
        int                        n;
        int                        kind;
        logic [fbc_pkg::SUM_W-1:0] stored;
        blk_q.delete();
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            blk_q.push_back(pick_word());
        end
        if (!mode_q) begin
            foreach (blk_q[k]) send_word(blk_q[k], k == blk_q.size() - 1, 1'b0, '0);
        end else begin
            kind   = $urandom_range(0, 15);
            stored = block_checksum(blk_q);
            case (kind)
                10, 11: stored = stored ^ (64'd1 << $urandom_range(0, 63));
                12:     stored = {$urandom, $urandom};
                14: begin
                    blk_q.delete();
                    stored = ($urandom_range(0, 1) == 1) ? ALL_ONES : {$urandom, $urandom};
                end
                15: begin
                    blk_q.delete();
                    stored = ALL_ONES;
                end
                default: ;
            endcase
            if (kind == 13) begin
                send_word(pick_word(), 1'b1, 1'b0, '0);
            end else begin
                send_word(stored[fbc_pkg::WORD_W-1:0], 1'b0, 1'b0, '0);
                send_word(stored[fbc_pkg::SUM_W-1:fbc_pkg::WORD_W], blk_q.size() == 0,
                          1'b0, '0);
                foreach (blk_q[k]) send_word(blk_q[k], k == blk_q.size() - 1, 1'b0, '0);
            end
        end
    endtask

    // receiver back-pressure, switching between four randomly chosen styles
    initial begin
        sum_ch.ready = 1'b1;
        stall_left   = 0;
        stall_style  = 0;
        stall_pat    = '0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 200);
            end
            stall_left--;
            stall_pat++;
            case (stall_style)
                0:       sum_ch.ready <= 1'b1;
                1:       sum_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       sum_ch.ready <= ($urandom_range(0, 3) == 0);
                default: sum_ch.ready <= (stall_pat[2:1] != 2'b11);
            endcase
        end
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && sum_ch.valid && sum_ch.ready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result checksum %h match %b short %b", $time,
                         sum_ch.checksum, sum_ch.matches_res, sum_ch.short_block);
                err_cnt++;
            end else begin
                head_res = pending_sums.pop_front();
                if (sum_ch.checksum !== head_res.sum64) begin
                    $display("%0t: checksum expected %h actual %h", $time,
                             head_res.sum64, sum_ch.checksum);
                    err_cnt++;
                end
                if (sum_ch.matches_res !== head_res.match_flag) begin
                    $display("%0t: match flag expected %b actual %b", $time,
                             head_res.match_flag, sum_ch.matches_res);
                    err_cnt++;
                end
                if (sum_ch.short_block !== head_res.short_flag) begin
                    $display("%0t: short flag expected %b actual %b", $time,
                             head_res.short_flag, sum_ch.short_block);
                    err_cnt++;
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        word_ch.valid     = 1'b0;
        word_ch.data_word = '0;
        word_ch.last_word = 1'b0;
        err_cnt           = 0;
        words_sent        = 0;
        burst_left        = 0;
        mode_q            = fbc_pkg::VERIFY_MODE_RESET;
        clear_block();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].is_cfg) begin
                drain();
                write_mode(dir_tab[i].cfg_val);
            end else begin
                send_word(dir_tab[i].word, dir_tab[i].last, dir_tab[i].has_exp,
                          '{dir_tab[i].exp_sum, dir_tab[i].exp_match, dir_tab[i].exp_short});
            end
        end

        // random phases, each starting from an idle block with a fresh mode
        while (words_sent < TARGET_WORDS) begin
            drain();
            write_mode(1'($urandom_range(0, 1)));
            repeat ($urandom_range(4, 20)) run_block();
        end

        drain();
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### fletcher64_block_checksum_top.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_ifs.sv
hw/rtl/fbc_accum.sv
hw/rtl/fbc_finish.sv
hw/rtl/fletcher64_block_checksum_top.sv
tb/testbench.sv
